[sv/prefix_route_table_core_assert.svh]
// assertion macros for the prefix route table core
// depends on clk and arst_n being visible where the macros are used
`ifndef PREFIX_ROUTE_TABLE_CORE_ASSERT_SVH
`define PREFIX_ROUTE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/prt_pkg.sv]
// shared types and constants of the prefix route table core
// no dependencies
package prt_pkg;

	// default table size
	localparam int TABLE_DEPTH_DEF = 32;

	// field widths
	localparam int OP_W     = 2;
	localparam int IP_W     = 32;
	localparam int RPOS_W   = 5;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 5;
	localparam int TCNT_W   = 6;

	// stream widths
	localparam int S_DATA_W = 136;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 80;
	localparam int M_USER_W = 3;

	// output tdata layout
	localparam int NH_LSB   = 0;
	localparam int DST_LSB  = NH_LSB + IP_W;
	localparam int POS_LSB  = DST_LSB + IP_W;
	localparam int TCNT_LSB = POS_LSB + POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic {
		KIND_DIRECT = 1'b0,
		KIND_USER   = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_PROTECTED = 3'd2,
		ST_NO_ENTRY  = 3'd3,
		ST_NO_ROUTE  = 3'd4
	} status_t;

	typedef struct packed {
		logic            direct;
		logic [IP_W-1:0] next_hop;
		logic [IP_W-1:0] mask;
		logic [IP_W-1:0] net;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_LU_SCAN,
		S_SL_SCAN,
		S_INS_START,
		S_INS_SHIFT,
		S_INS_WRITE,
		S_RM_SCAN,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		SCAN_NONE,
		SCAN_FWD_ALL,
		SCAN_INS,
		SCAN_RM
	} scan_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT_UP,
		WR_SHIFT_DN,
		WR_NEW
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		POS_NONE,
		POS_ZERO,
		POS_HIT,
		POS_COUNT
	} pos_op_t;

	typedef enum logic [3:0] {
		RES_NONE,
		RES_FULL,
		RES_NO_ENTRY,
		RES_PROT,
		RES_RM_OK,
		RES_ADD_OK,
		RES_HIT,
		RES_MISS,
		RES_NOP
	} res_op_t;

	// controller to datapath
	typedef struct packed {
		logic     load_item;
		scan_op_t scan_start;
		logic     scan_en;
		wr_op_t   wr_op;
		cnt_op_t  cnt_op;
		pos_op_t  pos_op;
		res_op_t  res_op;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            kind;
		logic            full;
		logic            rpos_bad;
		logic            lu_hit;
		logic            slot_hit;
		logic            scan_end;
		logic            rm_direct;
		logic            out_free;
	} stat_t;

endpackage

[sv/prefix_route_table_core.sv]
// top level of the prefix route table core: controller plus datapath
// depends on prt_pkg, prt_ctrl, prt_dpath and the assertion macro header
//
// channel   direction  tdata                                  tuser
// s_axis    in         net, mask, next hop, remove pos, addr  operation, route kind
// m_axis    out        next hop, deliver to, position, count  status
//
// one operation at a time: a lookup, add or remove completes before the next beat is taken
// every pass walks the entry memory through its single read port, one entry a cycle
// reset clears the entry count and handshake state; the entry memory is not cleared
// a stalled m_axis holds the result; the next beat is taken once it is loaded
`include "prefix_route_table_core_assert.svh"
module prefix_route_table_core
	import prt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// route_net, route_mask, route_next_hop, remove_position, lookup_address
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// operation, route_kind
	input  logic [S_USER_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// next_hop, deliver_to, position, table_count
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [M_USER_W-1:0] m_axis_tuser
);

	cmd_t  cmd;
	stat_t stat;

	// sequencing
	prt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table storage and compare
	prt_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	// checks
	`PRT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while an operation is in flight")
	`PRT_ASSERT_NOW(a_full_count, m_axis_tvalid && (m_axis_tuser == ST_FULL), m_axis_tdata[TCNT_LSB +: TCNT_W] == TCNT_W'(TABLE_DEPTH), "table full reported below depth")
	`PRT_ASSERT_NOW(a_miss_zero, m_axis_tvalid && (m_axis_tuser == ST_NO_ROUTE), (m_axis_tdata[NH_LSB +: IP_W] == '0) && (m_axis_tdata[POS_LSB +: POS_W] == '0), "route miss with nonzero hop or position")

endmodule

[sv/prt_ctrl.sv]
// controller state machine of the prefix route table core
// depends on prt_pkg for state, command and status types
module prt_ctrl
	import prt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op)
					OP_ADD: begin
						if (stat.full) begin
							state_d = S_RESP;
						end else if (stat.kind == KIND_DIRECT) begin
							state_d = S_INS_START;
						end else begin
							state_d = S_SL_SCAN;
						end
					end
					OP_REMOVE: begin
						state_d = stat.rpos_bad ? S_RESP : S_RM_SCAN;
					end
					OP_LOOKUP: begin
						state_d = S_LU_SCAN;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_LU_SCAN: begin
				if (stat.lu_hit || stat.scan_end) begin
					state_d = S_RESP;
				end
			end
			S_SL_SCAN: begin
				if (stat.slot_hit || stat.scan_end) begin
					state_d = S_INS_START;
				end
			end
			S_INS_START: begin
				state_d = S_INS_SHIFT;
			end
			S_INS_SHIFT: begin
				if (stat.scan_end) begin
					state_d = S_INS_WRITE;
				end
			end
			S_INS_WRITE: begin
				state_d = S_RESP;
			end
			S_RM_SCAN: begin
				if (stat.rm_direct || stat.scan_end) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd            = '0;
		cmd.scan_start = SCAN_NONE;
		cmd.wr_op      = WR_NONE;
		cmd.cnt_op     = CNT_HOLD;
		cmd.pos_op     = POS_NONE;
		cmd.res_op     = RES_NONE;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			S_DISPATCH: begin
				unique case (stat.op)
					OP_ADD: begin
						if (stat.full) begin
							cmd.res_op = RES_FULL;
						end else if (stat.kind == KIND_DIRECT) begin
							cmd.pos_op = POS_ZERO;
						end else begin
							cmd.scan_start = SCAN_FWD_ALL;
						end
					end
					OP_REMOVE: begin
						if (stat.rpos_bad) begin
							cmd.res_op = RES_NO_ENTRY;
						end else begin
							cmd.scan_start = SCAN_RM;
						end
					end
					OP_LOOKUP: begin
						cmd.scan_start = SCAN_FWD_ALL;
					end
					default: begin
						cmd.res_op = RES_NOP;
					end
				endcase
			end
			S_LU_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.lu_hit) begin
					cmd.res_op = RES_HIT;
				end else if (stat.scan_end) begin
					cmd.res_op = RES_MISS;
				end
			end
			S_SL_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.slot_hit) begin
					cmd.pos_op = POS_HIT;
				end else if (stat.scan_end) begin
					cmd.pos_op = POS_COUNT;
				end
			end
			S_INS_START: begin
				cmd.scan_start = SCAN_INS;
			end
			S_INS_SHIFT: begin
				cmd.scan_en = 1'b1;
				cmd.wr_op   = WR_SHIFT_UP;
			end
			S_INS_WRITE: begin
				cmd.wr_op  = WR_NEW;
				cmd.cnt_op = CNT_INC;
				cmd.res_op = RES_ADD_OK;
			end
			S_RM_SCAN: begin
				cmd.scan_en = 1'b1;
				cmd.wr_op   = WR_SHIFT_DN;
				if (stat.rm_direct) begin
					cmd.res_op = RES_PROT;
				end else if (stat.scan_end) begin
					cmd.cnt_op = CNT_DEC;
					cmd.res_op = RES_RM_OK;
				end
			end
			S_RESP: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[sv/prt_dpath.sv]
// datapath of the prefix route table core: entry memory, scan pointer,
// compare logic, result and output registers; depends on prt_pkg
module prt_dpath
	import prt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [S_DATA_W-1:0] in_data,
	input  logic [S_USER_W-1:0] in_user,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [M_DATA_W-1:0] out_data,
	output logic [M_USER_W-1:0] out_user
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// operation registers
	logic [OP_W-1:0]   op_q;
	logic              kind_q;
	logic [IP_W-1:0]   net_q;
	logic [IP_W-1:0]   mask_q;
	logic [IP_W-1:0]   nh_q;
	logic [RPOS_W-1:0] rpos_q;
	logic [IP_W-1:0]   addr_q;

	// table state and scan
	entry_t          mem [TABLE_DEPTH];
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rp_q;
	logic [CW-1:0]   rem_q;
	logic            dn_q;
	logic            dv_q;
	logic [AW-1:0]   ix_q;
	entry_t          rd_q;
	logic [IP_W-1:0] pm_q;
	logic [AW-1:0]   pos_q;

	// result hold and output registers
	status_t            res_status_q;
	logic [IP_W-1:0]    res_nh_q;
	logic [IP_W-1:0]    res_dst_q;
	logic [POS_W-1:0]   res_pos_q;
	logic               out_valid_q;
	logic [M_USER_W-1:0] out_user_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic          rd_en;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic [CW-1:0] rpos_cw;
	logic [AW-1:0] rpos_a;
	entry_t        new_entry;

	assign rpos_cw = CW'(rpos_q);
	assign rpos_a  = AW'(rpos_q);
	assign rd_en   = cmd.scan_en && (rem_q != '0);

	assign new_entry.direct   = (kind_q == KIND_DIRECT);
	assign new_entry.next_hop = nh_q;
	assign new_entry.mask     = mask_q;
	assign new_entry.net      = net_q;

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= in_user[OP_W-1:0];
			kind_q <= in_user[OP_W];
			net_q  <= in_data[0 +: IP_W];
			mask_q <= in_data[IP_W +: IP_W];
			nh_q   <= in_data[2*IP_W +: IP_W];
			rpos_q <= in_data[3*IP_W +: RPOS_W];
			addr_q <= in_data[3*IP_W+RPOS_W +: IP_W];
		end
	end

	// write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ix_q;
		wr_data = rd_q;
		unique case (cmd.wr_op)
			WR_SHIFT_UP: begin
				wr_en   = dv_q;
				wr_addr = ix_q + AW'(1);
			end
			WR_SHIFT_DN: begin
				wr_en   = dv_q && (ix_q != rpos_a);
				wr_addr = ix_q - AW'(1);
			end
			WR_NEW: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = new_entry;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rp_q[AW-1:0]];
		end
	end

	// scan pointer and remaining entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			rem_q <= '0;
			dn_q  <= 1'b0;
			dv_q  <= 1'b0;
			ix_q  <= '0;
		end else begin
			unique case (cmd.scan_start)
				SCAN_FWD_ALL: begin
					rp_q  <= '0;
					rem_q <= count_q;
					dn_q  <= 1'b0;
					dv_q  <= 1'b0;
				end
				SCAN_INS: begin
					rp_q  <= count_q - CW'(1);
					rem_q <= count_q - CW'(pos_q);
					dn_q  <= 1'b1;
					dv_q  <= 1'b0;
				end
				SCAN_RM: begin
					rp_q  <= rpos_cw;
					rem_q <= count_q - rpos_cw;
					dn_q  <= 1'b0;
					dv_q  <= 1'b0;
				end
				default: begin
					if (cmd.scan_en) begin
						if (rem_q != '0) begin
							rp_q  <= dn_q ? (rp_q - CW'(1)) : (rp_q + CW'(1));
							rem_q <= rem_q - CW'(1);
							dv_q  <= 1'b1;
							ix_q  <= rp_q[AW-1:0];
						end else begin
							dv_q <= 1'b0;
						end
					end
				end
			endcase
		end
	end

	// mask of the previous entry for the slot search
	always_ff @(posedge clk) begin
		if (cmd.scan_en && dv_q) begin
			pm_q <= rd_q.mask;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// insert position
	always_ff @(posedge clk) begin
		unique case (cmd.pos_op)
			POS_ZERO:  pos_q <= '0;
			POS_HIT:   pos_q <= ix_q;
			POS_COUNT: pos_q <= AW'(count_q);
			default:   pos_q <= pos_q;
		endcase
	end

	// result hold
	always_ff @(posedge clk) begin
		unique case (cmd.res_op)
			RES_NONE: begin
				res_status_q <= res_status_q;
			end
			RES_FULL: begin
				res_status_q <= ST_FULL;
				res_nh_q     <= '0;
				res_dst_q    <= '0;
				res_pos_q    <= '0;
			end
			RES_NO_ENTRY, RES_PROT, RES_RM_OK: begin
				res_status_q <= (cmd.res_op == RES_NO_ENTRY) ? ST_NO_ENTRY :
				                (cmd.res_op == RES_PROT) ? ST_PROTECTED : ST_OK;
				res_nh_q     <= '0;
				res_dst_q    <= '0;
				res_pos_q    <= rpos_q;
			end
			RES_ADD_OK: begin
				res_status_q <= ST_OK;
				res_nh_q     <= '0;
				res_dst_q    <= '0;
				res_pos_q    <= POS_W'(pos_q);
			end
			RES_HIT: begin
				res_status_q <= ST_OK;
				res_nh_q     <= rd_q.next_hop;
				res_dst_q    <= (rd_q.next_hop != '0) ? rd_q.next_hop : addr_q;
				res_pos_q    <= POS_W'(ix_q);
			end
			RES_MISS: begin
				res_status_q <= ST_NO_ROUTE;
				res_nh_q     <= '0;
				res_dst_q    <= '0;
				res_pos_q    <= '0;
			end
			default: begin
				res_status_q <= ST_OK;
				res_nh_q     <= '0;
				res_dst_q    <= '0;
				res_pos_q    <= '0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_user_q <= res_status_q;
			out_data_q <= {(M_DATA_W - TCNT_LSB - TCNT_W)'(0), TCNT_W'(count_q), res_pos_q,
			               res_dst_q, res_nh_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_user  = out_user_q;
	assign out_data  = out_data_q;

	// status to the controller
	always_comb begin
		stat.op        = op_q;
		stat.kind      = kind_q;
		stat.full      = (count_q == CW'(TABLE_DEPTH));
		stat.rpos_bad  = (32'(rpos_q) >= 32'(count_q));
		stat.lu_hit    = dv_q && ((addr_q & rd_q.mask) == rd_q.net);
		stat.slot_hit  = dv_q && (ix_q != '0) && (mask_q < pm_q) && (mask_q >= rd_q.mask);
		stat.scan_end  = !dv_q && (rem_q == '0);
		stat.rm_direct = dv_q && (ix_q == rpos_a) && rd_q.direct;
		stat.out_free  = !out_valid_q || out_ready;
	end

endmodule
